@@ rtl/core/sha_pkg.sv @@
// sha_pkg: constants, types and round functions for the sha-256 stream hasher
// no dependencies
`default_nettype none
package sha_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned NumWords = 8;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenW = 64;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t init_word(input logic [2:0] i);
    word_t w;
    case (i)
      3'd0: w = 32'h6a09e667;
      3'd1: w = 32'hbb67ae85;
      3'd2: w = 32'h3c6ef372;
      3'd3: w = 32'ha54ff53a;
      3'd4: w = 32'h510e527f;
      3'd5: w = 32'h9b05688c;
      3'd6: w = 32'h1f83d9ab;
      3'd7: w = 32'h5be0cd19;
      default: w = '0;
    endcase
    return w;
  endfunction

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [6:0] LenPos = 7'd56;

  function automatic word_t ror(input word_t x, input int unsigned s);
    return (x >> s) | (x << (WordW - s));
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/sha_round.sv @@
// sha_round: one shared compression round with rolling 16-word schedule
// depends on sha_pkg
`default_nettype none
module sha_round (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire logic          step,
  input  wire logic [5:0]    rnd,
  input  wire sha_pkg::word_t blk_w [16],
  input  wire sha_pkg::word_t h_in  [8],
  output sha_pkg::word_t     r_out [8]
);
  import sha_pkg::*;
  word_t w_r [16];
  word_t v_r [8];
  word_t s0, s1, t1, t2, wn, w0;

  always_comb begin
    w0 = w_r[0];
    s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
    t1 = v_r[7] + (ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + RoundK[rnd] + w0;
    t2 = (ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      w_r <= blk_w;
      v_r <= h_in;
    end else if (step) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end
  assign r_out = v_r;
endmodule
`default_nettype wire

@@ rtl/core/sha256_stream_hasher.sv @@
// sha256_stream_hasher: byte-stream sha-256 with eight-word digest output
// depends on sha_pkg and sha_round
// a byte item that leaves the block part-full keeps in_tready high; the byte that fills
// the block starts a compression (load, 64 rounds, fold) before in_tready returns
// a closing item adds padding at one byte a cycle up to the block end, one or two
// compressions, then eight digest items at one a cycle at most
// the single shared round unit limits the byte rate: no bytes are taken while a block compresses
// reset: synchronous active low, clears control, chaining words to initial values
`default_nettype none
module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tuser,   // byte_valid
  input  wire logic        in_tlast,   // end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // digest_word
  output logic [2:0]       out_tuser,  // word_index
  output logic             out_tlast   // last_word
);
  import sha_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_LOAD = 6'b000010, S_RUN = 6'b000100,
    S_FOLD = 6'b001000, S_PAD  = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  word_t       blk_r [16];          // block buffer as big-endian words, one byte lane per write
  logic [5:0]  fill_r;              // bytes held in the block, wraps to 0 at a full block
  logic [LenW-1:0] len_r;           // message length in bytes
  logic [LenW-1:0] bits_r;          // bit length latched at the close
  word_t h_r [NumWords];            // chaining words
  logic [5:0]  rnd_r;
  logic        fin_r;               // closing in progress
  logic        mark_r;              // 0x80 marker still to be written
  logic        lenblk_r;            // current block carries the bit length
  logic [2:0]  oi_r;
  word_t r_out [8];
  logic        wr_en, acc;
  logic [7:0]  wr_b;

  sha_round u_round (
    .clk(clk), .load(state_r == S_LOAD), .step(state_r == S_RUN),
    .rnd(rnd_r), .blk_w(blk_r), .h_in(h_r), .r_out(r_out)
  );

  assign in_tready = (state_r == S_IDLE);
  assign acc = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = h_r[oi_r];
  assign out_tuser = oi_r;
  assign out_tlast = (oi_r == 3'd7);

  // at most one byte write per cycle: message byte on accept of a valid byte, else marker, zero or length byte
  always_comb begin
    wr_en = 1'b0;
    wr_b  = in_tdata;
    if (acc && in_tuser) begin
      wr_en = 1'b1;
    end else if (state_r == S_PAD) begin
      wr_en = 1'b1;
      if (mark_r) wr_b = PadByte;
      else if (lenblk_r && fill_r >= LenPos[5:0]) wr_b = bits_r[{~fill_r[2:0], 3'b000} +: 8];
      else wr_b = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) blk_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= wr_b;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (acc) begin
        if (in_tuser && fill_r == 6'd63) state_nxt = S_LOAD;
        else if (in_tlast) state_nxt = S_PAD;
      end
      S_LOAD: state_nxt = S_RUN;
      S_RUN:  if (rnd_r == 6'd63) state_nxt = S_FOLD;
      // after a close the length block is the last one, else keep padding
      S_FOLD: begin
        if (!fin_r) state_nxt = S_IDLE;
        else if (lenblk_r) state_nxt = S_OUT;
        else state_nxt = S_PAD;
      end
      S_PAD:  if (fill_r == 6'd63) state_nxt = S_LOAD;
      S_OUT:  if (out_tready && oi_r == 3'd7) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; fill_r <= '0; len_r <= '0; bits_r <= '0; rnd_r <= '0;
      fin_r <= 1'b0; mark_r <= 1'b0; lenblk_r <= 1'b0; oi_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_word(3'(i));
    end else begin
      state_r <= state_nxt;
      if (wr_en) fill_r <= fill_r + 6'd1;
      if (state_r == S_RUN) rnd_r <= rnd_r + 6'd1;
      if (acc) begin
        if (in_tuser) len_r <= len_r + 64'd1;
        if (in_tlast) begin
          fin_r <= 1'b1;
          mark_r <= 1'b1;
          bits_r <= (len_r + {63'd0, in_tuser}) << 3;
        end
      end
      // the length fits behind the marker only if the marker lands before byte 56
      if (state_r == S_PAD && mark_r) begin
        mark_r <= 1'b0;
        lenblk_r <= (fill_r < LenPos[5:0]);
      end
      if (state_r == S_FOLD) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + r_out[i];
        if (fin_r && !mark_r) lenblk_r <= 1'b1;
      end
      if (state_r == S_OUT && out_tready) begin
        oi_r <= oi_r + 3'd1;
        if (oi_r == 3'd7) begin
          fin_r <= 1'b0; lenblk_r <= 1'b0; len_r <= '0;
          for (int i = 0; i < 8; i++) h_r[i] <= init_word(3'(i));
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// tb: self-checking testbench for sha256_stream_hasher
// depends on sha_pkg and the rtl of the hasher; drives byte items, checks digest words
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import sha_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } byte_item_t;

  typedef struct packed {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last_word;
  } digest_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // data_byte
  logic        in_tuser;   // byte_valid
  logic        in_tlast;   // end_of_message
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // digest_word
  logic [2:0]  out_tuser;  // word_index
  logic        out_tlast;  // last_word

  sha256_stream_hasher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  localparam word_t RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam word_t StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam int unsigned TimeoutCycles = 400000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned LongHold = 300;

  // predictor state: chaining words, pending block, fill, byte count
  word_t       hash_state [8];
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  logic [63:0] msg_bytes;

  byte_item_t   pending_items [$];
  digest_item_t expected_digest [$];
  logic         stim_done;
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;

  function automatic word_t rotr(input word_t x, input int unsigned s);
    return (x >> s) | (x << (32 - s));
  endfunction

  // one 64-round compression of the pending block into the chaining words
  task automatic compress_block();
    word_t w [64];
    word_t v [8];
    word_t t1;
    word_t t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + w[t-7]
           + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
           + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    v = hash_state;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    blk_bytes[blk_fill] = b;
    blk_fill++;
    if (blk_fill == 64) begin
      compress_block();
      blk_fill = 0;
    end
  endtask

  // model one accepted item; a close pads, finishes and queues eight digest words
  task automatic hash_item(input byte_item_t it);
    logic [63:0]  bit_len;
    digest_item_t d;
    if (it.byte_valid) begin
      absorb_byte(it.data_byte);
      msg_bytes++;
    end
    if (it.end_of_message) begin
      bit_len = msg_bytes << 3;
      absorb_byte(PadByte);
      while (blk_fill != 56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(bit_len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_state[i];
        d.word_index = 3'(i);
        d.last_word = (i == 7);
        expected_digest.push_back(d);
      end
      hash_state = StartHash;
      blk_fill = 0;
      msg_bytes = '0;
    end
  endtask

  function automatic byte_item_t mk_item(input logic [7:0] b, input logic v,
                                         input logic e);
    byte_item_t it;
    it.data_byte = b;
    it.byte_valid = v;
    it.end_of_message = e;
    return it;
  endfunction

  // queue a message of n random bytes, sprinkled with empty items, closed on the last byte or by a bare item
  task automatic queue_message(input int unsigned n, input bit close_with_byte);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        pending_items.push_back(mk_item(8'($urandom), 1'b0, 1'b0));
      if (close_with_byte && i == n - 1)
        pending_items.push_back(mk_item(8'($urandom), 1'b1, 1'b1));
      else
        pending_items.push_back(mk_item(8'($urandom), 1'b1, 1'b0));
    end
    if (!close_with_byte || n == 0)
      pending_items.push_back(mk_item(8'($urandom), 1'b0, 1'b1));
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // stimulus: directed messages first, then random ones
  initial begin
    stim_done = 1'b0;
    hash_state = StartHash;
    blk_fill = 0;
    msg_bytes = '0;
    // empty message, closed by an item carrying no byte
    pending_items.push_back(mk_item(8'hff, 1'b0, 1'b1));
    // one byte, closed on the same item, extremes of the byte
    pending_items.push_back(mk_item(8'h00, 1'b1, 1'b1));
    pending_items.push_back(mk_item(8'hff, 1'b1, 1'b1));
    // a run of alternating-bit bytes with an empty item between, closed by a bare item
    pending_items.push_back(mk_item(8'haa, 1'b1, 1'b0));
    pending_items.push_back(mk_item(8'h55, 1'b0, 1'b0));
    pending_items.push_back(mk_item(8'h55, 1'b1, 1'b0));
    pending_items.push_back(mk_item(8'h00, 1'b0, 1'b1));
    // padding boundaries: 55 fits one block, 56 and 64 need a second
    queue_message(55, 1'b1);
    queue_message(56, 1'b0);
    queue_message(64, 1'b1);
    // random part, short messages
    while (pending_items.size() < 210) begin
      queue_message($urandom_range(0, 12), $urandom_range(0, 1));
    end
    stim_done = 1'b1;
  end

  // driver: offers queued items with random gaps
  int unsigned send_gap;
  byte_item_t  cur_item;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
      in_tlast <= 1'b0;
      send_gap <= 0;
    end else if (in_tvalid && !in_tready) begin
      // holding the offered item
    end else begin
      if (in_tvalid) hash_item(cur_item);
      if (send_gap != 0 || pending_items.size() == 0) begin
        in_tvalid <= 1'b0;
        if (send_gap != 0) send_gap <= send_gap - 1;
      end else begin
        cur_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= cur_item.data_byte;
        in_tuser <= cur_item.byte_valid;
        in_tlast <= cur_item.end_of_message;
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
    end
  end

  // receiver back-pressure, with one long hold-off at the first digest word
  int unsigned stall_left;
  int unsigned hold_left;
  logic        hold_done;
  int unsigned rx_wait;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && out_tvalid) begin
      out_tready <= 1'b0;
      hold_left <= LongHold;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= (stall_left == 1);
      stall_left <= stall_left - 1;
    end else if (out_tvalid && out_tready) begin
      rx_wait = $urandom_range(0, 6);
      stall_left <= rx_wait;
      out_tready <= (rx_wait == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: compares each digest word with the oldest expectation
  digest_item_t exp_word;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_digest.size() == 0) begin
        $error("unexpected digest word %h", out_tdata);
        fail_count++;
      end else begin
        exp_word = expected_digest.pop_front();
        if (out_tdata !== exp_word.digest_word) begin
          $error("digest_word expected %h actual %h", exp_word.digest_word, out_tdata);
          fail_count++;
        end
        if (out_tuser !== exp_word.word_index) begin
          $error("word_index expected %0d actual %0d", exp_word.word_index, out_tuser);
          fail_count++;
        end
        if (out_tlast !== exp_word.last_word) begin
          $error("last_word expected %0b actual %0b", exp_word.last_word, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TimeoutCycles) begin
      $display("FAIL sha256_stream_hasher");
      $finish;
    end
  end

  // end of run: all items sent, all words seen, then a short drain
  initial begin
    wait (stim_done && rst_n);
    wait (pending_items.size() == 0 && !in_tvalid);
    @(posedge clk);
    wait (expected_digest.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && expected_digest.size() == 0) begin
      $display("PASS sha256_stream_hasher");
    end else begin
      $display("FAIL sha256_stream_hasher");
    end
    $finish;
  end
endmodule
`default_nettype wire
